>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked during reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constants and types of the bit pattern stream matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

   localparam int MAX_BITS_DEFAULT = 64;   // longest pattern that is compared
   localparam int BYTE_W           = 8;    // stream bits per transfer
   localparam int PATTERN_W        = 64;   // width of the pattern register
   localparam int LENGTH_W         = 7;    // width of the length register
   localparam int SEEN_W           = 7;    // width of the bit counter
   localparam int SEEN_MAX         = 127;  // counter saturates here
   localparam int OFFSET_W         = 3;    // bit position inside a byte
   localparam int CSR_INDEX_W      = 2;    // width of the register index

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd8;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD   = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1
   } csr_index_type;

   // Per-cell shift control
   typedef struct packed {
      logic shift;   // take the neighbor's byte
      logic clear;   // load zero instead (start of stream)
   } cell_ctrl_type;

   // Compare result for one byte
   typedef struct packed {
      logic                match;
      logic [OFFSET_W-1:0] offset;
   } window_result_type;

endpackage

`default_nettype wire

>>> rtl/bit_pattern_stream_matcher.sv
// ----------------------------------------------------------------------------
// bit_pattern_stream_matcher
// Result: registered, shown in the cycle after its byte transfer.
// Throughput: one byte per cycle while the result output is not stalled; the
// compare of all eight end positions and the shift of the history cell chain
// both finish in the transfer cycle. Reset: synchronous; clears history, bit
// count, found flag and output valid; pattern word resets to 0, length to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_pattern_stream_matcher
   import bsm_pkg::*;
#(
   parameter int MAX_PATTERN_BITS = MAX_BITS_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // byte input
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic                   req_start_of_stream,
   // result output
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic                        rsp_match_in_byte,
   output logic [OFFSET_W-1:0]         rsp_end_offset,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [PATTERN_W-1:0]   csr_wdata
);

   localparam int NUM_CELLS = (MAX_PATTERN_BITS + BYTE_W - 2) / BYTE_W;
   localparam int HIST_W    = NUM_CELLS * BYTE_W;

   logic [PATTERN_W-1:0] pattern_word_ff, pattern_word_in;
   logic [LENGTH_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [SEEN_W-1:0]    seen_ff, seen_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic                 rsp_match_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;

   logic                 accept;
   logic                 sos;
   logic [HIST_W-1:0]    hist_all;
   logic [MAX_PATTERN_BITS-2:0] hist_eff;
   logic [SEEN_W-1:0]    seen_eff;
   logic [SEEN_W:0]      seen_sum;
   window_result_type    win_res;

   logic [BYTE_W-1:0]    cell_byte [NUM_CELLS];
   cell_ctrl_type        cell_ctrl [NUM_CELLS];

   // handshake: output register frees up as it is read
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign sos       = req_start_of_stream;
   assign csr_ready = 1'b1;

   // history cell chain, cell 0 holds the newest byte
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic [BYTE_W-1:0] neighbor;

      if (i == 0) begin : g_head
         assign neighbor          = req_data_byte;
         assign cell_ctrl[i].clear = 1'b0;
      end else begin : g_body
         assign neighbor          = cell_byte[i-1];
         assign cell_ctrl[i].clear = sos;
      end
      assign cell_ctrl[i].shift = accept;

      bsm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .byte_in  (neighbor),
         .byte_out (cell_byte[i])
      );

      assign hist_all[i*BYTE_W +: BYTE_W] = cell_byte[i];
   end

   // state as seen by this byte
   assign hist_eff = sos ? '0 : hist_all[MAX_PATTERN_BITS-2:0];
   assign seen_eff = sos ? '0 : seen_ff;

   bsm_window #(
      .MAX_PATTERN_BITS (MAX_PATTERN_BITS)
   ) u_window (
      .history        (hist_eff),
      .data_byte      (req_data_byte),
      .bits_seen      (seen_eff),
      .pattern_word   (pattern_word_ff),
      .pattern_length (pattern_length_ff),
      .result         (win_res)
   );

   // counter, sticky flag and output valid
   always_comb begin
      seen_sum = {1'b0, seen_eff} + (SEEN_W + 1)'(BYTE_W);
      seen_in  = seen_ff;
      found_in = found_ff;
      if (accept) begin
         seen_in  = (seen_sum > (SEEN_W + 1)'(SEEN_MAX))
                    ? SEEN_W'(SEEN_MAX) : seen_sum[SEEN_W-1:0];
         found_in = (found_ff && !sos) || win_res.match;
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   // register writes
   always_comb begin
      pattern_word_in   = pattern_word_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_WORD:   pattern_word_in   = csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_in = csr_wdata[LENGTH_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_word_ff   <= '0;
         pattern_length_ff <= LENGTH_RESET;
         seen_ff           <= '0;
         found_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_word_ff   <= pattern_word_in;
         pattern_length_ff <= pattern_length_in;
         seen_ff           <= seen_in;
         found_ff          <= found_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_found_ff  <= found_in;
         rsp_match_ff  <= win_res.match;
         rsp_offset_ff <= win_res.offset;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_in_byte = rsp_match_ff;
   assign rsp_end_offset    = rsp_offset_ff;

endmodule

`default_nettype wire

>>> rtl/bsm_cell.sv
// ----------------------------------------------------------------------------
// bsm_cell
// One byte of stream history; hands its byte to the next cell on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_cell
   import bsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [BYTE_W-1:0] byte_in,
   output logic      [BYTE_W-1:0] byte_out
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_mux;

   // next value: neighbor byte, or zero when the stream restarts
   always_comb begin
      byte_in_mux = ctrl.clear ? '0 : byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (ctrl.shift) begin
         byte_ff <= byte_in_mux;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

>>> rtl/bsm_window.sv
// ----------------------------------------------------------------------------
// bsm_window
// Compares the eight windows that end at the bit positions of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_window
   import bsm_pkg::*;
#(
   parameter int MAX_PATTERN_BITS = MAX_BITS_DEFAULT
)(
   input  wire logic [MAX_PATTERN_BITS-2:0] history,
   input  wire logic [BYTE_W-1:0]           data_byte,
   input  wire logic [SEEN_W-1:0]           bits_seen,
   input  wire logic [PATTERN_W-1:0]        pattern_word,
   input  wire logic [LENGTH_W-1:0]         pattern_length,
   output window_result_type                result
);

   localparam int STREAM_W = MAX_PATTERN_BITS - 1 + BYTE_W;

   logic [STREAM_W-1:0]         stream;
   logic [LENGTH_W-1:0]         len_c;
   logic [PATTERN_W-1:0]        want_full;
   logic [MAX_PATTERN_BITS-1:0] want;
   logic [MAX_PATTERN_BITS-1:0] mask;
   logic [MAX_PATTERN_BITS-1:0] win;
   logic [BYTE_W-1:0]           hit_vec;
   logic [SEEN_W:0]             avail;

   assign stream = {history, data_byte};

   // clamp length and line the pattern up with the low window bits
   always_comb begin
      len_c     = (pattern_length > LENGTH_W'(MAX_PATTERN_BITS))
                  ? LENGTH_W'(MAX_PATTERN_BITS) : pattern_length;
      want_full = pattern_word >> (LENGTH_W'(PATTERN_W) - len_c);
      want      = want_full[MAX_PATTERN_BITS-1:0];
      for (int i = 0; i < MAX_PATTERN_BITS; i++) begin
         mask[i] = (LENGTH_W'(i) < len_c);
      end
   end

   // one compare per end position, bit 0 of the byte (MSB) first
   always_comb begin
      hit_vec = '0;
      win     = '0;
      avail   = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         win        = stream[(BYTE_W - 1 - k) +: MAX_PATTERN_BITS];
         avail      = {1'b0, bits_seen} + (SEEN_W + 1)'(k + 1);
         hit_vec[k] = (len_c != '0) && (avail >= {1'b0, len_c})
                      && (((win ^ want) & mask) == '0);
      end
   end

   // earliest end position wins
   always_comb begin
      result.match  = |hit_vec;
      result.offset = '0;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            result.offset = OFFSET_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks of the bit pattern stream matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bsm_checker
   import bsm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_found,
   input wire logic                rsp_match_in_byte,
   input wire logic [OFFSET_W-1:0] rsp_end_offset
);

   logic rsp_stall;
   logic rsp_no_hit;
   logic rsp_hit;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_no_hit = rsp_valid && !rsp_match_in_byte;
   assign rsp_hit    = rsp_valid && rsp_match_in_byte;

   // a waiting result is not dropped
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "result dropped")

   // no match means offset zero
   `CHK_IMPLIES(a_offset_zero, clock, reset, rsp_no_hit, rsp_end_offset == '0, "offset w/o match")

   // a match in this byte sets found
   `CHK_IMPLIES(a_match_found, clock, reset, rsp_hit, rsp_found, "match without found")

   // nothing is shown right after reset
   `CHK_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind bit_pattern_stream_matcher bsm_checker u_bsm_checker (.*);

`default_nettype wire
